### sv/gcfs_pkg.sv
// Shared types and codes for the greedy conflict-free selection block.
package gcfs_pkg;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_PAIR  = 3'd2;
    localparam logic [2:0] OP_RUN   = 3'd3;
    localparam logic [2:0] OP_RANK  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [24:0] SUM_MAX = 25'd33554431;
    localparam int          ADJ_W   = 64;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  index_a;
        logic [7:0]  index_b;
        logic [15:0] score;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  kept_count;
        logic [24:0] total_score;
        logic        score_valid;
        logic [7:0]  match_index;
    } t_out_word;

endpackage

### sv/greedy_conflict_free_selection.sv
// Top level of the greedy conflict-free selection block.
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in_word  (gcfs_pkg::t_in_word)
//  out       output     o_out_valid / i_out_ready     o_out_word (gcfs_pkg::t_out_word)
//  cfg       input      psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// Load and rank without conflicts need no RAM read; rank otherwise reads the kept list.
// A conflict pair does two read-modify-writes of the adjacency RAM.
// Run time for n loaded matches is set by the score-RAM scan that picks each next
// match and by the adjacency row read per match.
// Reset and clear sweep the whole adjacency RAM with o_in_ready low. A finished
// word waits in the output register; a new word is taken while it waits, and the
// next result holds until the output register frees.
module greedy_conflict_free_selection #(
    parameter int MAX_MATCHES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gcfs_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gcfs_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW    = $clog2(MAX_MATCHES);
    localparam int CW    = $clog2(MAX_MATCHES + 1);
    localparam int XW    = (CW > 8) ? CW : 8;
    localparam int WPR   = (MAX_MATCHES + gcfs_pkg::ADJ_W - 1) / gcfs_pkg::ADJ_W;
    localparam int WIW   = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int DEPTH = MAX_MATCHES * WPR;
    localparam int AW    = $clog2(DEPTH);
    localparam int PADW  = WPR * gcfs_pkg::ADJ_W;

    typedef enum logic [3:0] {
        S_WIPE, S_IDLE, S_PAIR_RD, S_PAIR_WR, S_PAIR_RD2, S_PAIR_WR2,
        S_SCAN, S_CHECK, S_RANK_RD, S_RANK_WT, S_DONE
    } t_state;

    t_state                r_state;
    gcfs_pkg::t_in_word    r_in;
    gcfs_pkg::t_out_word   r_out;
    logic                  r_ov;
    logic                  r_report;
    logic [AW-1:0]         r_wa;
    logic [15:0]           r_eps;
    logic [CW-1:0]         r_count;
    logic                  r_any;
    logic [CW-1:0]         r_kt;
    logic [24:0]           r_sum;
    logic                  r_sval;
    logic                  r_ident;
    logic [PADW-1:0]       r_marks;
    logic [15:0]           r_pbest;
    logic [IW-1:0]         r_pidx;
    logic [1:0]            r_status;
    logic [7:0]            r_mindex;
    logic [CW-1:0]         r_iter;
    logic [CW-1:0]         r_si;
    logic                  r_sv;
    logic [IW-1:0]         r_sd;
    logic                  r_have;
    logic [15:0]           r_best;
    logic [IW-1:0]         r_bidx;
    logic [WIW:0]          r_cw;
    logic                  r_cv;
    logic [WIW-1:0]        r_cwd;
    logic                  r_conf;

    logic                  acc;
    logic [IW-1:0]         ia_idx, ib_idx;
    logic [15:0]           ia_ext, ib_ext;
    logic [WIW-1:0]        ia_word, ib_word;
    logic [5:0]            ia_bit, ib_bit;
    logic                  sc_we;
    logic [IW-1:0]         sc_waddr, sc_raddr;
    logic [15:0]           sc_rdata;
    logic                  adj_we;
    logic [AW-1:0]         adj_waddr, adj_raddr;
    logic [63:0]           adj_wdata, adj_rdata;
    logic                  kl_we;
    logic [IW-1:0]         kl_raddr;
    logic [IW-1:0]         kl_rdata;
    logic [16:0]           add_v;
    logic [25:0]           sum_v;
    logic [24:0]           sum_sat;
    logic [63:0]           mark_slice;

    function automatic logic [AW-1:0] row_addr(input logic [IW-1:0] r, input logic [WIW-1:0] w);
        row_addr = AW'(AW'(r) * AW'(WPR) + AW'(w));
    endfunction

    assign acc     = i_in_valid && o_in_ready;
    assign ia_idx  = IW'(r_in.index_a);
    assign ib_idx  = IW'(r_in.index_b);
    assign ia_ext  = 16'(ia_idx);
    assign ib_ext  = 16'(ib_idx);
    assign ia_word = WIW'(ia_ext[15:6]);
    assign ib_word = WIW'(ib_ext[15:6]);
    assign ia_bit  = ia_ext[5:0];
    assign ib_bit  = ib_ext[5:0];

    assign add_v      = {1'b0, r_best} + {1'b0, r_eps};
    assign sum_v      = {1'b0, r_sum} + 26'(add_v);
    assign sum_sat    = (sum_v > 26'(gcfs_pkg::SUM_MAX)) ? gcfs_pkg::SUM_MAX : sum_v[24:0];
    assign mark_slice = r_marks[r_cwd*gcfs_pkg::ADJ_W +: gcfs_pkg::ADJ_W];

    always_comb begin
        sc_we     = (r_state == S_IDLE) && 1'b0;
        sc_waddr  = IW'(r_count);
        sc_raddr  = IW'(r_si);
        adj_we    = 1'b0;
        adj_waddr = r_wa;
        adj_wdata = '0;
        adj_raddr = row_addr(r_bidx, WIW'(r_cw));
        kl_we     = 1'b0;
        kl_raddr  = ia_idx;
        case (r_state)
            S_WIPE: begin
                adj_we = 1'b1;
            end
            S_PAIR_RD: begin
                adj_raddr = row_addr(ia_idx, ib_word);
            end
            S_PAIR_WR: begin
                adj_we    = 1'b1;
                adj_waddr = row_addr(ia_idx, ib_word);
                adj_wdata = adj_rdata | (64'd1 << ib_bit);
            end
            S_PAIR_RD2: begin
                adj_raddr = row_addr(ib_idx, ia_word);
            end
            S_PAIR_WR2: begin
                adj_we    = 1'b1;
                adj_waddr = row_addr(ib_idx, ia_word);
                adj_wdata = adj_rdata | (64'd1 << ia_bit);
            end
            S_CHECK: begin
                kl_we = (r_cw == (WIW+1)'(WPR)) && !r_cv && !r_conf && !(|mark_slice & r_cv);
            end
            default: begin
            end
        endcase
        if (acc && i_in_word.operation == gcfs_pkg::OP_LOAD
                && r_count != CW'(MAX_MATCHES)) begin
            sc_we = 1'b1;
        end
    end

    gcfs_ram #(.WIDTH(16), .DEPTH(MAX_MATCHES)) u_score (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(i_in_word.score),
        .i_raddr(sc_raddr), .o_rdata(sc_rdata)
    );

    gcfs_ram #(.WIDTH(gcfs_pkg::ADJ_W), .DEPTH(DEPTH)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );

    gcfs_ram #(.WIDTH(IW), .DEPTH(MAX_MATCHES)) u_kept (
        .i_clk(i_clk), .i_we(kl_we), .i_waddr(IW'(r_kt)), .i_wdata(r_bidx),
        .i_raddr(kl_raddr), .o_rdata(kl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_WIPE;
            r_ov     <= 1'b0;
            r_report <= 1'b0;
            r_wa     <= '0;
            r_eps    <= '0;
            r_count  <= '0;
            r_any    <= 1'b0;
            r_kt     <= '0;
            r_sum    <= '0;
            r_sval   <= 1'b0;
            r_ident  <= 1'b0;
            r_marks  <= '0;
            r_sv     <= 1'b0;
            r_cv     <= 1'b0;
        end else begin
            if (psel && penable && pwrite && !paddr[2]) begin
                r_eps <= pwdata[15:0];
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_WIPE: begin
                    r_wa <= r_wa + AW'(1);
                    if (r_wa == AW'(DEPTH - 1)) begin
                        r_state <= r_report ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_in     <= i_in_word;
                        r_status <= gcfs_pkg::ST_OK;
                        r_mindex <= '0;
                        r_state  <= S_DONE;
                        case (i_in_word.operation)
                            gcfs_pkg::OP_CLEAR: begin
                                r_count  <= '0;
                                r_any    <= 1'b0;
                                r_kt     <= '0;
                                r_sum    <= '0;
                                r_sval   <= 1'b0;
                                r_ident  <= 1'b0;
                                r_marks  <= '0;
                                r_wa     <= '0;
                                r_report <= 1'b1;
                                r_state  <= S_WIPE;
                            end
                            gcfs_pkg::OP_LOAD: begin
                                if (r_count == CW'(MAX_MATCHES)) begin
                                    r_status <= gcfs_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            gcfs_pkg::OP_PAIR: begin
                                if (XW'(i_in_word.index_a) >= XW'(r_count)
                                        || XW'(i_in_word.index_b) >= XW'(r_count)) begin
                                    r_status <= gcfs_pkg::ST_BAD;
                                end else begin
                                    r_any   <= 1'b1;
                                    r_state <= S_PAIR_RD;
                                end
                            end
                            gcfs_pkg::OP_RUN: begin
                                r_kt    <= '0;
                                r_sum   <= '0;
                                r_sval  <= 1'b0;
                                r_ident <= 1'b0;
                                r_marks <= '0;
                                if (r_count != '0) begin
                                    if (!r_any) begin
                                        r_ident <= 1'b1;
                                        r_kt    <= r_count;
                                    end else begin
                                        r_sval  <= 1'b1;
                                        r_iter  <= '0;
                                        r_si    <= '0;
                                        r_sv    <= 1'b0;
                                        r_have  <= 1'b0;
                                        r_state <= S_SCAN;
                                    end
                                end
                            end
                            gcfs_pkg::OP_RANK: begin
                                if (XW'(i_in_word.index_a) >= XW'(r_kt)) begin
                                    r_status <= gcfs_pkg::ST_BAD;
                                end else if (r_ident) begin
                                    r_mindex <= i_in_word.index_a;
                                end else begin
                                    r_state <= S_RANK_RD;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PAIR_RD: r_state <= S_PAIR_WR;
                S_PAIR_WR: r_state <= S_PAIR_RD2;
                S_PAIR_RD2: r_state <= S_PAIR_WR2;
                S_PAIR_WR2: r_state <= S_DONE;
                S_SCAN: begin
                    if (r_si != r_count) begin
                        r_sd <= IW'(r_si);
                        r_si <= r_si + CW'(1);
                        r_sv <= 1'b1;
                    end else begin
                        r_sv <= 1'b0;
                    end
                    if (r_sv && (r_iter == '0 || sc_rdata < r_pbest
                                 || (sc_rdata == r_pbest && r_sd > r_pidx))
                            && (!r_have || sc_rdata > r_best)) begin
                        r_have <= 1'b1;
                        r_best <= sc_rdata;
                        r_bidx <= r_sd;
                    end
                    if (r_si == r_count && !r_sv) begin
                        r_pbest <= r_best;
                        r_pidx  <= r_bidx;
                        r_cw    <= '0;
                        r_cv    <= 1'b0;
                        r_conf  <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cw != (WIW+1)'(WPR)) begin
                        r_cwd <= WIW'(r_cw);
                        r_cw  <= r_cw + (WIW+1)'(1);
                        r_cv  <= 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (r_cv && |(adj_rdata & mark_slice)) begin
                        r_conf <= 1'b1;
                    end
                    if (r_cw == (WIW+1)'(WPR) && !r_cv) begin
                        if (!r_conf) begin
                            r_marks[r_bidx] <= 1'b1;
                            r_kt            <= r_kt + CW'(1);
                            r_sum           <= sum_sat;
                        end
                        r_iter <= r_iter + CW'(1);
                        r_si   <= '0;
                        r_sv   <= 1'b0;
                        r_have <= 1'b0;
                        r_state <= (r_iter == r_count - CW'(1)) ? S_DONE : S_SCAN;
                    end
                end
                S_RANK_RD: r_state <= S_RANK_WT;
                S_RANK_WT: begin
                    r_mindex <= 8'(kl_rdata);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_out.status      <= r_status;
                        r_out.kept_count  <= 9'(r_kt);
                        r_out.total_score <= r_sum;
                        r_out.score_valid <= r_sval;
                        r_out.match_index <= r_mindex;
                        r_ov              <= 1'b1;
                        r_report          <= 1'b0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;
    assign prdata      = paddr[2] ? 32'd0 : {16'd0, r_eps};
    assign pready      = 1'b1;

endmodule

### sv/gcfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gcfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
